// File: hw/rtl/ddpid_pkg.sv
// ----------------------------------------------------------------------------
// ddpid_pkg
// Shared widths, register indexes, reset values and the command/status
// types of the differential-drive PID step unit.
// ----------------------------------------------------------------------------
package ddpid_pkg;

   // Field widths
   localparam int COUNT_WIDTH  = 24;
   localparam int SENSOR_WIDTH = 12;
   localparam int GAIN_W       = 16;
   localparam int BASE_W       = 14;
   localparam int THR_W        = 12;
   localparam int DRIVE_W      = 16;
   localparam int SUM_W        = 32;
   localparam int FRAC_SHIFT   = 8;
   localparam int IR_FRAC      = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   // Derived datapath widths
   localparam int DIFF_W  = COUNT_WIDTH + 1;
   localparam int SD_W    = SENSOR_WIDTH + 1;
   localparam int E_W     = ((DIFF_W + IR_FRAC > SD_W + GAIN_W + 1) ?
                             DIFF_W + IR_FRAC : SD_W + GAIN_W + 1) + 1;
   localparam int ERR_W   = E_W - IR_FRAC;
   localparam int DD_W    = ERR_W + 1;
   localparam int SUMX_W  = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
   localparam int MUL_A_W = (SUM_W > DD_W) ? SUM_W : DD_W;
   localparam int MUL_B_W = GAIN_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int Q_W     = ACC_W - FRAC_SHIFT;
   localparam int CORR_W  = BASE_W + 1;
   localparam int CMP_W   = (SENSOR_WIDTH > THR_W) ? SENSOR_WIDTH : THR_W;

   // Register reset values
   localparam logic [GAIN_W-1:0] KP_RESET        = GAIN_W'(16777);
   localparam logic [GAIN_W-1:0] KI_RESET        = GAIN_W'(0);
   localparam logic [GAIN_W-1:0] KD_RESET        = GAIN_W'(0);
   localparam logic [GAIN_W-1:0] IR_WEIGHT_RESET = GAIN_W'(1638);
   localparam logic [BASE_W-1:0] BASE_RESET      = BASE_W'(3277);
   localparam logic [THR_W-1:0]  WALL_L_RESET    = THR_W'(1050);
   localparam logic [THR_W-1:0]  WALL_R_RESET    = THR_W'(1250);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KP_GAIN     = 3'd0,
      REG_KI_GAIN     = 3'd1,
      REG_KD_GAIN     = 3'd2,
      REG_IR_WEIGHT   = 3'd3,
      REG_BASE_SPEED  = 3'd4,
      REG_WALL_LEFT   = 3'd5,
      REG_WALL_RIGHT  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp_gain;
      logic [GAIN_W-1:0] ki_gain;
      logic [GAIN_W-1:0] kd_gain;
      logic [GAIN_W-1:0] ir_weight;
      logic [BASE_W-1:0] base_speed;
      logic [THR_W-1:0]  wall_left_threshold;
      logic [THR_W-1:0]  wall_right_threshold;
   } cfg_type;

   typedef enum logic [1:0] {
      MUL_IR,
      MUL_KP,
      MUL_KI,
      MUL_KD
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_IR_MUL,
      ST_ERR,
      ST_KP_MUL,
      ST_KI_MUL,
      ST_KD_MUL,
      ST_ACC_LAST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        err_en;
      logic        prep_en;
      logic        acc_en;
      logic        finish;
   } dp_cmd_type;

   typedef struct packed {
      logic wall_hit;
   } dp_status_type;

endpackage

// File: hw/rtl/differential_drive_pid_step_unit.sv
// ----------------------------------------------------------------------------
// differential_drive_pid_step_unit
// One PID control tick for a two-wheel drive: front wall stop, encoder plus
// side IR error, saturating integral, clamped correction to both drives.
//
//   channel  direction  handshake           word
//   req_     in         req_valid/req_stall  restart, counts, four IR readings
//   rsp_     out        rsp_valid/rsp_stall  left/right drive, at_wall
//   csr_     in         csr_valid/csr_ready  register index, write data
//
// A driving tick is one pass of the sequencer through the shared multiplier
// (IR weight, kp, ki, kd) and the accumulator; a wall tick goes from accept
// straight to finish and skips both.
// Reset is synchronous; it restores the register defaults and zeroes the
// integral and previous error. A stalled result word holds in the output
// register; the next word is accepted meanwhile and waits before its finish.
// ----------------------------------------------------------------------------
module differential_drive_pid_step_unit
   import ddpid_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_restart,
   input  logic signed [COUNT_WIDTH-1:0]  req_left_count,
   input  logic signed [COUNT_WIDTH-1:0]  req_right_count,
   input  logic [SENSOR_WIDTH-1:0]        req_side_left_ir,
   input  logic [SENSOR_WIDTH-1:0]        req_side_right_ir,
   input  logic [SENSOR_WIDTH-1:0]        req_front_left_ir,
   input  logic [SENSOR_WIDTH-1:0]        req_front_right_ir,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [DRIVE_W-1:0]      rsp_left_drive,
   output logic signed [DRIVE_W-1:0]      rsp_right_drive,
   output logic                           rsp_at_wall,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   ddpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ddpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ddpid_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .req_restart        (req_restart),
      .req_left_count     (req_left_count),
      .req_right_count    (req_right_count),
      .req_side_left_ir   (req_side_left_ir),
      .req_side_right_ir  (req_side_right_ir),
      .req_front_left_ir  (req_front_left_ir),
      .req_front_right_ir (req_front_right_ir),
      .rsp_left_drive     (rsp_left_drive),
      .rsp_right_drive    (rsp_right_drive),
      .rsp_at_wall        (rsp_at_wall)
   );

endmodule

// File: hw/rtl/ddpid_csr.sv
// ----------------------------------------------------------------------------
// ddpid_csr
// Configuration register file: gains, side IR weight, base speed and the
// front wall thresholds.
// ----------------------------------------------------------------------------
module ddpid_csr
   import ddpid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_KP_GAIN:    cfg_in.kp_gain              = csr_wdata[GAIN_W-1:0];
            REG_KI_GAIN:    cfg_in.ki_gain              = csr_wdata[GAIN_W-1:0];
            REG_KD_GAIN:    cfg_in.kd_gain              = csr_wdata[GAIN_W-1:0];
            REG_IR_WEIGHT:  cfg_in.ir_weight            = csr_wdata[GAIN_W-1:0];
            REG_BASE_SPEED: cfg_in.base_speed           = csr_wdata[BASE_W-1:0];
            REG_WALL_LEFT:  cfg_in.wall_left_threshold  = csr_wdata[THR_W-1:0];
            REG_WALL_RIGHT: cfg_in.wall_right_threshold = csr_wdata[THR_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain              <= KP_RESET;
         cfg_ff.ki_gain              <= KI_RESET;
         cfg_ff.kd_gain              <= KD_RESET;
         cfg_ff.ir_weight            <= IR_WEIGHT_RESET;
         cfg_ff.base_speed           <= BASE_RESET;
         cfg_ff.wall_left_threshold  <= WALL_L_RESET;
         cfg_ff.wall_right_threshold <= WALL_R_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/ddpid_ctrl.sv
// ----------------------------------------------------------------------------
// ddpid_ctrl
// Sequencer for one control tick: steers the shared multiplier and the
// accumulator, and owns the result word's valid flag.
// ----------------------------------------------------------------------------
module ddpid_ctrl
   import ddpid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // the output register can take a new word when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_IR;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.wall_hit ? ST_FINISH : ST_IR_MUL;
            end
         end
         ST_IR_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_IR;
            state_in    = ST_ERR;
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
            state_in   = ST_KP_MUL;
         end
         ST_KP_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_KP;
            cmd.prep_en = 1'b1;
            state_in    = ST_KI_MUL;
         end
         ST_KI_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_KI;
            cmd.acc_en  = 1'b1;
            state_in    = ST_KD_MUL;
         end
         ST_KD_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_KD;
            cmd.acc_en  = 1'b1;
            state_in    = ST_ACC_LAST;
         end
         ST_ACC_LAST: begin
            cmd.acc_en = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register frees up
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/ddpid_datapath.sv
// ----------------------------------------------------------------------------
// ddpid_datapath
// Error formation, saturating integral, shared gain multiplier, accumulator,
// correction clamp and the drive output register.
// ----------------------------------------------------------------------------
module ddpid_datapath
   import ddpid_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  dp_cmd_type                     cmd,
   output dp_status_type                  status,
   input  logic                           req_restart,
   input  logic signed [COUNT_WIDTH-1:0]  req_left_count,
   input  logic signed [COUNT_WIDTH-1:0]  req_right_count,
   input  logic [SENSOR_WIDTH-1:0]        req_side_left_ir,
   input  logic [SENSOR_WIDTH-1:0]        req_side_right_ir,
   input  logic [SENSOR_WIDTH-1:0]        req_front_left_ir,
   input  logic [SENSOR_WIDTH-1:0]        req_front_right_ir,
   output logic signed [DRIVE_W-1:0]      rsp_left_drive,
   output logic signed [DRIVE_W-1:0]      rsp_right_drive,
   output logic                           rsp_at_wall
);

   // tick operands
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [SD_W-1:0]    sd_ff;
   logic                      wall_ff;
   // persistent controller state
   logic signed [SUM_W-1:0]   error_sum_ff;
   logic signed [ERR_W-1:0]   last_error_ff;
   // working registers
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [ERR_W-1:0]   err_in;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [DD_W-1:0]    dd_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [DRIVE_W-1:0] left_ff;
   logic signed [DRIVE_W-1:0] right_ff;
   logic                      at_wall_ff;

   logic [CMP_W-1:0]          fl_ext;
   logic [CMP_W-1:0]          fr_ext;
   logic [CMP_W-1:0]          thr_l_ext;
   logic [CMP_W-1:0]          thr_r_ext;

   logic signed [MUL_A_W-1:0] mul_a;
   logic [GAIN_W-1:0]         mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   logic signed [E_W-1:0]     e_full;
   logic                      round_up;
   logic signed [SUMX_W-1:0]  sumx;
   logic                      sum_ovf;
   logic signed [DD_W-1:0]    dd_in;

   logic signed [Q_W-1:0]     q;
   logic signed [Q_W-1:0]     base_q;
   logic signed [CORR_W-1:0]  base_c;
   logic signed [CORR_W-1:0]  corr;
   logic signed [DRIVE_W-1:0] base_d;
   logic signed [DRIVE_W-1:0] corr_d;

   // front wall check on the incoming word
   assign fl_ext    = CMP_W'(req_front_left_ir);
   assign fr_ext    = CMP_W'(req_front_right_ir);
   assign thr_l_ext = CMP_W'(cfg.wall_left_threshold);
   assign thr_r_ext = CMP_W'(cfg.wall_right_threshold);
   assign status.wall_hit = (fl_ext >= thr_l_ext) || (fr_ext >= thr_r_ext);

   // shared multiplier: signed operand times unsigned gain
   always_comb begin
      case (cmd.mul_sel)
         MUL_IR: begin
            mul_a = MUL_A_W'(sd_ff);
            mul_b = cfg.ir_weight;
         end
         MUL_KP: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = cfg.kp_gain;
         end
         MUL_KI: begin
            mul_a = MUL_A_W'(sum_ff);
            mul_b = cfg.ki_gain;
         end
         default: begin
            mul_a = MUL_A_W'(dd_ff);
            mul_b = cfg.kd_gain;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * $signed(PROD_W'({1'b0, mul_b}));

   // error: truncate (diff * 2^16 + weighted IR difference) / 2^16 toward zero
   assign e_full   = $signed({{(ERR_W - DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff,
                              {IR_FRAC{1'b0}}}) + prod_ff[E_W-1:0];
   assign round_up = e_full[E_W-1] && (|e_full[IR_FRAC-1:0]);
   assign err_in   = e_full[E_W-1:IR_FRAC] + $signed({{(ERR_W-1){1'b0}}, round_up});

   // saturating integral and derivative difference
   assign sumx    = SUMX_W'(error_sum_ff) + SUMX_W'(err_ff);
   assign sum_ovf = sumx[SUMX_W-1:SUM_W-1] != {(SUMX_W-SUM_W+1){sumx[SUM_W-1]}};
   assign sum_in  = !sum_ovf ? sumx[SUM_W-1:0] :
                    sumx[SUMX_W-1] ? $signed({1'b1, {(SUM_W-1){1'b0}}}) :
                                     $signed({1'b0, {(SUM_W-1){1'b1}}});
   assign dd_in   = DD_W'(err_ff) - DD_W'(last_error_ff);

   // floor shift and clamp to +/- base speed
   assign q      = acc_ff[ACC_W-1:FRAC_SHIFT];
   assign base_q = $signed({{(Q_W-BASE_W){1'b0}}, cfg.base_speed});
   assign base_c = $signed({1'b0, cfg.base_speed});
   always_comb begin
      if (q > base_q) begin
         corr = base_c;
      end else if (q < -base_q) begin
         corr = -base_c;
      end else begin
         corr = q[CORR_W-1:0];
      end
   end
   assign base_d = $signed({{(DRIVE_W-BASE_W){1'b0}}, cfg.base_speed});
   assign corr_d = DRIVE_W'(corr);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         diff_ff <= DIFF_W'(req_left_count) - DIFF_W'(req_right_count);
         sd_ff   <= $signed({1'b0, req_side_right_ir}) - $signed({1'b0, req_side_left_ir});
         wall_ff <= status.wall_hit;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.err_en) begin
         err_ff <= err_in;
      end
      if (cmd.prep_en) begin
         sum_ff <= sum_in;
         dd_ff  <= dd_in;
         acc_ff <= '0;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.finish) begin
         if (wall_ff) begin
            left_ff    <= '0;
            right_ff   <= '0;
            at_wall_ff <= 1'b1;
         end else begin
            left_ff    <= base_d - corr_d;
            right_ff   <= base_d + corr_d;
            at_wall_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (cmd.load && req_restart) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (cmd.finish && !wall_ff) begin
         error_sum_ff  <= sum_ff;
         last_error_ff <= err_ff;
      end
   end

   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;
   assign rsp_at_wall     = at_wall_ff;

endmodule
